>>> hdl/rbba_pkg.sv
// ----------------------------------------------------------------------------
// rbba_pkg: shared types and constants for box binning average
// Item and result payloads, queue entry, register indexes, state types.
// ----------------------------------------------------------------------------
package rbba_pkg;

  localparam int BIN_ADDR_W = 16;
  localparam logic [12:0] COUNT_MAX = 13'd8191;

  localparam logic [2:0] REG_X_START    = 3'd0;
  localparam logic [2:0] REG_X_STOP     = 3'd1;
  localparam logic [2:0] REG_Y_START    = 3'd2;
  localparam logic [2:0] REG_Y_STOP     = 3'd3;
  localparam logic [2:0] REG_BIN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_BIN_HEIGHT = 3'd5;
  localparam logic [2:0] REG_GAIN       = 3'd6;
  localparam logic [2:0] REG_SHIFT      = 3'd7;

  typedef enum logic {
    OP_ACCUMULATE = 1'b0,
    OP_READ       = 1'b1
  } op_e;

  typedef struct packed {
    logic        operation;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] sample;
    logic [11:0] bin_index;
  } item_t;

  typedef struct packed {
    logic [47:0] average;
    logic        has_data;
    logic [12:0] pixel_count;
  } result_t;

  typedef struct packed {
    logic [11:0] x_start;
    logic [11:0] x_stop;
    logic [11:0] y_start;
    logic [11:0] y_stop;
    logic [6:0]  bin_width;
    logic [6:0]  bin_height;
    logic [31:0] gain;
    logic [47:0] shift;
  } cfg_t;

  typedef struct packed {
    op_e                   kind;
    logic                  in_range;
    logic [BIN_ADDR_W-1:0] addr;
    logic [47:0]           value;
  } q_entry_t;

  typedef struct packed {
    logic [63:0] sum;
    logic [12:0] count;
  } bin_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_EXEC,
    B_DIV,
    B_OUT
  } back_state_e;

endpackage

>>> hdl/rbba_queue.sv
// ----------------------------------------------------------------------------
// rbba_queue: two-entry queue between front and back
// Plain FIFO of classified operations.
// ----------------------------------------------------------------------------
module rbba_queue import rbba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_entry,
  output logic     empty
);

  q_entry_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign empty     = (fill == 2'd0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> hdl/rbba_front.sv
// ----------------------------------------------------------------------------
// rbba_front: item intake and bin classification
// Window test, bin index by serial division, affine correction with clamp.
// ----------------------------------------------------------------------------
module rbba_front import rbba_pkg::*; #(
  parameter int MAX_BINS     = 4096,
  parameter int MAX_COORD    = 4096,
  parameter int MAX_BIN_SIDE = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     accept,
  input  item_t    item,
  output logic     busy,
  output logic     push,
  output q_entry_t push_entry,
  input  logic     q_full
);

  localparam logic [16:0] COORD_LIM = 17'(MAX_COORD - 1);
  localparam logic [16:0] COORD_END = 17'(MAX_COORD);
  localparam logic [8:0]  SIDE_LIM  = 9'(MAX_BIN_SIDE);
  localparam logic [24:0] BIN_END   = 25'(MAX_BINS);

  front_state_e state, state_next;

  logic [11:0] xa, xb, ya, yb, xlo, xhi, ylo, yhi;
  logic [7:0]  bw, bh;
  logic        in_window;

  op_e         kind;
  logic        rd_in_range;
  logic [11:0] rd_addr;
  logic [11:0] quo_x, quo_y, quo_s;
  logic [7:0]  rem_x, rem_y, rem_s;
  logic [7:0]  bw_q, bh_q;
  logic [3:0]  step;
  logic [31:0] sample;
  logic [63:0] prod;
  logic [24:0] rowmul;

  logic signed [64:0] corr;
  logic [47:0]        corr_sat;
  logic [24:0]        bin_num;
  logic               keep;

  function automatic logic [19:0] div_step(input logic [7:0] rem, input logic [11:0] quo,
                                           input logic [7:0] d);
    logic [8:0] t;
    logic [8:0] r;
    logic       b;
    t = {rem, quo[11]};
    b = (t >= {1'b0, d});
    r = b ? (t - {1'b0, d}) : t;
    return {r[7:0], quo[10:0], b};
  endfunction

  function automatic logic [11:0] clamp_coord(input logic [11:0] c);
    return ({5'd0, c} > COORD_LIM) ? COORD_LIM[11:0] : c;
  endfunction

  function automatic logic [7:0] clamp_side(input logic [6:0] s);
    if (s == 7'd0) begin
      return 8'd1;
    end
    return ({2'd0, s} > SIDE_LIM) ? SIDE_LIM[7:0] : {1'b0, s};
  endfunction

  always_comb begin
    xa = clamp_coord(cfg.x_start);
    xb = clamp_coord(cfg.x_stop);
    ya = clamp_coord(cfg.y_start);
    yb = clamp_coord(cfg.y_stop);
    xlo = (xa < xb) ? xa : xb;
    xhi = (xa < xb) ? xb : xa;
    ylo = (ya < yb) ? ya : yb;
    yhi = (ya < yb) ? yb : ya;
    bw = clamp_side(cfg.bin_width);
    bh = clamp_side(cfg.bin_height);
    in_window = ({5'd0, item.pixel_x} < COORD_END) && ({5'd0, item.pixel_y} < COORD_END) &&
                (item.pixel_x >= xlo) && (item.pixel_x <= xhi) &&
                (item.pixel_y >= ylo) && (item.pixel_y <= yhi);
  end

  // correction: exact sum, then saturate to the 48-bit range
  always_comb begin
    corr = $signed({prod[63], prod}) + 65'($signed(cfg.shift));
    if (corr[64:47] == {18{corr[64]}}) begin
      corr_sat = corr[47:0];
    end else if (corr[64]) begin
      corr_sat = {1'b1, 47'd0};
    end else begin
      corr_sat = {1'b0, {47{1'b1}}};
    end
    bin_num = rowmul + 25'(quo_x);
    keep    = (bin_num < BIN_END);
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          if (op_e'(item.operation) == OP_READ) begin
            state_next = F_PUSH;
          end else if (in_window) begin
            state_next = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (step == 4'd11) begin
          state_next = F_MUL;
        end
      end
      F_MUL: state_next = F_PUSH;
      F_PUSH: begin
        if ((kind == OP_ACCUMULATE && !keep) || !q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != F_IDLE);
    push = (state == F_PUSH) && !q_full && (kind == OP_READ || keep);
    push_entry.kind     = kind;
    push_entry.in_range = rd_in_range;
    push_entry.addr     = (kind == OP_READ) ? BIN_ADDR_W'(rd_addr) : bin_num[BIN_ADDR_W-1:0];
    push_entry.value    = corr_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        kind        <= op_e'(item.operation);
        rd_addr     <= item.bin_index;
        rd_in_range <= ({5'd0, item.bin_index} < BIN_END[16:0]);
        quo_x       <= item.pixel_x - xlo;
        quo_y       <= item.pixel_y - ylo;
        quo_s       <= xhi - xlo;
        rem_x       <= 8'd0;
        rem_y       <= 8'd0;
        rem_s       <= 8'd0;
        bw_q        <= bw;
        bh_q        <= bh;
        sample      <= item.sample;
        step        <= 4'd0;
      end
      F_DIV: begin
        {rem_x, quo_x} <= div_step(rem_x, quo_x, bw_q);
        {rem_y, quo_y} <= div_step(rem_y, quo_y, bh_q);
        {rem_s, quo_s} <= div_step(rem_s, quo_s, bw_q);
        step           <= step + 4'd1;
      end
      F_MUL: begin
        prod   <= 64'($signed(cfg.gain) * $signed(sample));
        rowmul <= quo_y * ({1'b0, quo_s} + 13'd1);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/rbba_back.sv
// ----------------------------------------------------------------------------
// rbba_back: bin store and read-out
// Read-modify-write of sums and counts, serial divide for the average.
// ----------------------------------------------------------------------------
module rbba_back import rbba_pkg::*; #(
  parameter int MAX_BINS = 4096
) (
  input  logic     clk,
  input  logic     rst,
  input  q_entry_t entry,
  input  logic     q_empty,
  output logic     pop,
  output logic     clearing,
  output logic     result_valid,
  output result_t  result
);

  localparam int ABITS = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [ABITS-1:0] LAST_ADDR = ABITS'(MAX_BINS - 1);

  back_state_e state, state_next;

  bin_t             mem [MAX_BINS];
  bin_t             rd_data;
  q_entry_t         cur;
  logic [ABITS-1:0] clr_addr;

  logic             we;
  logic [ABITS-1:0] waddr;
  bin_t             wdata;

  logic        neg;
  logic [63:0] quo;
  logic [13:0] rem;
  logic [12:0] divisor;
  logic [5:0]  step;
  logic [13:0] t;
  logic        tb;
  logic [63:0] quo_signed;

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: if (clr_addr == LAST_ADDR) state_next = B_IDLE;
      B_IDLE:  if (!q_empty) state_next = B_READ;
      B_READ:  state_next = B_EXEC;
      B_EXEC: begin
        if (cur.kind == OP_READ && cur.in_range && rd_data.count != 13'd0) begin
          state_next = B_DIV;
        end else begin
          state_next = B_IDLE;
        end
      end
      B_DIV:   if (step == 6'd63) state_next = B_OUT;
      B_OUT:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE) && !q_empty;
    clearing = (state == B_CLEAR);
    we       = 1'b0;
    waddr    = cur.addr[ABITS-1:0];
    wdata    = '0;
    case (state)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      B_EXEC: begin
        if (cur.kind == OP_ACCUMULATE) begin
          we          = (rd_data.count != COUNT_MAX);
          wdata.sum   = rd_data.sum + 64'($signed(cur.value));
          wdata.count = rd_data.count + 13'd1;
        end else begin
          we = cur.in_range;
        end
      end
      default: begin
      end
    endcase
    t          = {rem[12:0], quo[63]};
    tb         = (t >= {1'b0, divisor});
    quo_signed = neg ? (64'd0 - quo) : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + ABITS'(1);
      end
      if (state == B_OUT) begin
        result_valid <= 1'b1;
      end
      if (state == B_EXEC && cur.kind == OP_READ &&
          !(cur.in_range && rd_data.count != 13'd0)) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[cur.addr[ABITS-1:0]];
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur <= entry;
      end
      B_EXEC: begin
        neg     <= rd_data.sum[63];
        quo     <= rd_data.sum[63] ? (64'd0 - rd_data.sum) : rd_data.sum;
        rem     <= 14'd0;
        divisor <= rd_data.count;
        step    <= 6'd0;
        result  <= '0;
      end
      B_DIV: begin
        rem  <= tb ? (t - {1'b0, divisor}) : t;
        quo  <= {quo[62:0], tb};
        step <= step + 6'd1;
      end
      B_OUT: begin
        result.average     <= quo_signed[47:0];
        result.has_data    <= 1'b1;
        result.pixel_count <= divisor;
      end
      default: begin
      end
    endcase
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe longer than one cycle");

  a_no_result_clear: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !result_valid) else $error("result during clearing pass");

  a_has_data_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.has_data) |-> (result.pixel_count != 13'd0))
    else $error("data flagged with zero count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.has_data) |->
      (result.average == 48'd0 && result.pixel_count == 13'd0))
    else $error("empty bin result not zero");

endmodule

>>> hdl/region_box_binning_average_top.sv
// ----------------------------------------------------------------------------
// region_box_binning_average_top: rebin an image window into box averages
// Accumulates corrected pixels into bins; reads return and clear a bin mean.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every address of the bin
// store, with busy high; register writes are taken during it. An item is
// accepted when start is high and busy is low. After it accepts an accumulate
// that lands in the window, the front holds busy through the serial bin-index
// division, the multiply and the push; after a read, through the push; after
// an accumulate outside the window, not at all. Either hold is longer while
// the two-entry queue to the back is full and an entry is to be pushed. The
// back handles an accumulate, or a read of an empty or out-of-range bin, as
// pop, memory read and update; a read of a filled bin adds a 64-step average
// division and an output step. A read result appears on result for exactly
// one cycle with result_valid high; the receiver cannot stall it, so it must
// take every transfer. Accumulates produce no result. Register writes must
// only be made with the block idle and all reads delivered.
// ----------------------------------------------------------------------------
module region_box_binning_average_top import rbba_pkg::*; #(
  parameter int MAX_BINS     = 4096,
  parameter int MAX_COORD    = 4096,
  parameter int MAX_BIN_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        result_valid,
  output result_t     result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  cfg_t     cfg;
  logic     front_busy;
  logic     clearing;
  logic     push, q_full, q_empty, pop;
  q_entry_t push_entry, pop_entry;

  // register file, to be written by the user only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_start    <= 12'd0;
      cfg.x_stop     <= 12'd4095;
      cfg.y_start    <= 12'd0;
      cfg.y_stop     <= 12'd4095;
      cfg.bin_width  <= 7'd1;
      cfg.bin_height <= 7'd1;
      cfg.gain       <= 32'd65536;
      cfg.shift      <= 48'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_X_START:    cfg.x_start    <= cfg_data[11:0];
        REG_X_STOP:     cfg.x_stop     <= cfg_data[11:0];
        REG_Y_START:    cfg.y_start    <= cfg_data[11:0];
        REG_Y_STOP:     cfg.y_stop     <= cfg_data[11:0];
        REG_BIN_WIDTH:  cfg.bin_width  <= cfg_data[6:0];
        REG_BIN_HEIGHT: cfg.bin_height <= cfg_data[6:0];
        REG_GAIN:       cfg.gain       <= cfg_data[31:0];
        REG_SHIFT:      cfg.shift      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // hold off intake while the store is being cleared
  assign busy = front_busy || clearing;

  rbba_front #(
    .MAX_BINS    (MAX_BINS),
    .MAX_COORD   (MAX_COORD),
    .MAX_BIN_SIDE(MAX_BIN_SIDE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (start && !busy),
    .item      (item),
    .busy      (front_busy),
    .push      (push),
    .push_entry(push_entry),
    .q_full    (q_full)
  );

  rbba_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .pop_entry (pop_entry),
    .empty     (q_empty)
  );

  rbba_back #(
    .MAX_BINS(MAX_BINS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (pop_entry),
    .q_empty     (q_empty),
    .pop         (pop),
    .clearing    (clearing),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
